// ===== src/postfix_stack_evaluator_unit_assert.svh =====
// Assertion macros used by the checker of the postfix evaluator.
`ifndef POSTFIX_STACK_EVALUATOR_UNIT_ASSERT_SVH
`define POSTFIX_STACK_EVALUATOR_UNIT_ASSERT_SVH

// Same-cycle implication, muted while reset is held.
`define PSE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("postfix evaluator check failed");

// Next-cycle implication, muted while reset is held.
`define PSE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("postfix evaluator check failed");

`endif

// ===== src/pse_pkg.sv =====
`default_nettype none

package pse_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 16;
  localparam int unsigned QUEUE_DEPTH     = 2;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned NUM_W    = 31;
  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned DEPTH_W  = 5;
  localparam int unsigned STATUS_W = 2;

  localparam logic [FUNC_W-1:0] FUNC_PUSH = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_ADD  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_SUB  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_MUL  = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_DIV  = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNDER = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVER  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_DIVZ  = 2'd3;

  typedef enum logic [2:0] {
    K_PUSH,
    K_ADD,
    K_SUB,
    K_MUL,
    K_DIV,
    K_NOP
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [NUM_W-1:0]  number;
    logic              last;
  } item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_MULW,
    S_DIVW,
    S_FILL,
    S_FIN
  } state_e;

endpackage

`default_nettype wire

// ===== src/pse_if.sv =====
`default_nettype none

interface pse_in_if;
  import pse_pkg::*;
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [NUM_W-1:0]    number;
  logic                last_token;

  modport source (output valid, func, number, last_token, input ready);
  modport sink   (input valid, func, number, last_token, output ready);
endinterface

interface pse_out_if;
  import pse_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [DATA_W-1:0]   top_value;
  logic [DEPTH_W-1:0]         depth;
  logic [STATUS_W-1:0]        status;
  logic                       last;

  modport source (output valid, top_value, depth, status, last, input ready);
  modport sink   (input valid, top_value, depth, status, last, output ready);
endinterface

`default_nettype wire

// ===== src/pse_div.sv =====
`default_nettype none

module pse_div import pse_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [DATA_W-1:0] dividend_i,
  input  wire logic [DATA_W-1:0] divisor_i,
  output logic                   done_o,
  output logic [DATA_W-1:0]      quo_o
);

  localparam int unsigned StepW = $clog2(DATA_W + 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [StepW-1:0]  step_q, step_d;
  logic [DATA_W:0]   rem_q, rem_d;
  logic [DATA_W-1:0] quo_q, quo_d;
  logic [DATA_W-1:0] dsr_q, dsr_d;
  logic              neg_q, neg_d;
  logic [DATA_W:0]   rem_sh;
  logic [DATA_W:0]   diff;

  assign rem_sh = {rem_q[DATA_W-1:0], quo_q[DATA_W-1]};
  assign diff   = rem_sh - {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    neg_d  = neg_q;
    if (start_i) begin
      // work on magnitudes, fix the sign at the end
      busy_d = 1'b1;
      step_d = StepW'(DATA_W);
      rem_d  = '0;
      quo_d  = dividend_i[DATA_W-1] ? (DATA_W'(0) - dividend_i) : dividend_i;
      dsr_d  = divisor_i[DATA_W-1] ? (DATA_W'(0) - divisor_i) : divisor_i;
      neg_d  = dividend_i[DATA_W-1] ^ divisor_i[DATA_W-1];
    end else if (busy_q) begin
      if (!diff[DATA_W]) begin
        rem_d = diff;
        quo_d = {quo_q[DATA_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        quo_d = {quo_q[DATA_W-2:0], 1'b0};
      end
      step_d = step_q - StepW'(1);
      if (step_q == StepW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
    neg_q <= neg_d;
  end

  assign done_o = done_q;
  assign quo_o  = neg_q ? (DATA_W'(0) - quo_q) : quo_q;

endmodule

`default_nettype wire

// ===== src/pse_front.sv =====
`default_nettype none

module pse_front import pse_pkg::*; (
  pse_in_if.sink     in_i,
  input  wire logic  full_i,
  output logic       wr_valid_o,
  output item_t      wr_item_o
);

  kind_e kind;

  // classify the token kind; unknown codes become a no-op
  always_comb begin
    unique case (in_i.func)
      FUNC_PUSH: kind = K_PUSH;
      FUNC_ADD:  kind = K_ADD;
      FUNC_SUB:  kind = K_SUB;
      FUNC_MUL:  kind = K_MUL;
      FUNC_DIV:  kind = K_DIV;
      default:   kind = K_NOP;
    endcase
  end

  assign in_i.ready        = !full_i;
  assign wr_valid_o        = in_i.valid && !full_i;
  assign wr_item_o.kind    = kind;
  assign wr_item_o.number  = in_i.number;
  assign wr_item_o.last    = in_i.last_token;

endmodule

`default_nettype wire

// ===== src/pse_fifo.sv =====
`default_nettype none

module pse_fifo import pse_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  wr_valid_i,
  input  item_t      wr_item_i,
  output logic       full_o,
  output logic       rd_valid_o,
  output item_t      rd_item_o,
  input  wire logic  rd_pop_i
);

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  item_t           slot_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wptr_q, wptr_d;
  logic [PtrW-1:0] rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_wr, do_rd;

  assign full_o     = (cnt_q == CntW'(QUEUE_DEPTH));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_item_o  = slot_q[rptr_q];
  assign do_wr      = wr_valid_i && !full_o;
  assign do_rd      = rd_pop_i && rd_valid_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_wr) begin
      wptr_d = (wptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + PtrW'(1);
    end
    if (do_rd) begin
      rptr_d = (rptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + PtrW'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      slot_q[wptr_q] <= wr_item_i;
    end
  end

endmodule

`default_nettype wire

// ===== src/pse_back.sv =====
`default_nettype none

module pse_back import pse_pkg::*; #(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   q_valid_i,
  input  item_t       q_item_i,
  output logic        q_pop_o,
  pse_out_if.source   out_o
);

  localparam int unsigned CntW  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AddrW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  state_e              state_q, state_d;
  item_t               item_q, item_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [DATA_W-1:0]   tos_q, tos_d;
  logic [DATA_W-1:0]   nos_q, nos_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [DATA_W-1:0]   mul_q;
  logic [DATA_W-1:0]   rd_q;
  logic [DATA_W-1:0]   mem_q [STACK_DEPTH];

  logic                out_valid_q, out_valid_d;
  logic [DATA_W-1:0]   out_top_q, out_top_d;
  logic [DEPTH_W-1:0]  out_depth_q, out_depth_d;
  logic [STATUS_W-1:0] out_status_q, out_status_d;
  logic                out_last_q, out_last_d;

  logic                mem_we, rd_en, div_start, div_done, do_pop;
  logic [DATA_W-1:0]   pop_val, div_quo;
  logic [CntW-1:0]     waddr_full, raddr_full;

  pse_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (nos_q),
    .divisor_i  (tos_q),
    .done_o     (div_done),
    .quo_o      (div_quo)
  );

  // entries below the two top registers live in memory
  assign waddr_full = cnt_q - CntW'(2);
  assign raddr_full = cnt_q - CntW'(3);

  always_comb begin
    state_d      = state_q;
    item_d       = item_q;
    cnt_d        = cnt_q;
    tos_d        = tos_q;
    nos_d        = nos_q;
    status_d     = status_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_top_d    = out_top_q;
    out_depth_d  = out_depth_q;
    out_status_d = out_status_q;
    out_last_d   = out_last_q;
    q_pop_o      = 1'b0;
    mem_we       = 1'b0;
    rd_en        = 1'b0;
    div_start    = 1'b0;
    do_pop       = 1'b0;
    pop_val      = '0;

    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          item_d  = q_item_i;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        status_d = ST_OK;
        state_d  = S_FIN;
        unique case (item_q.kind)
          K_PUSH: begin
            if (cnt_q == CntW'(STACK_DEPTH)) begin
              status_d = ST_OVER;
            end else begin
              mem_we = (cnt_q >= CntW'(2));
              nos_d  = tos_q;
              tos_d  = {1'b0, item_q.number};
              cnt_d  = cnt_q + CntW'(1);
            end
          end
          K_NOP: begin
            status_d = ST_OK;
          end
          default: begin
            if (cnt_q < CntW'(2)) begin
              status_d = ST_UNDER;
            end else begin
              case (item_q.kind)
                K_ADD: begin
                  do_pop  = 1'b1;
                  pop_val = nos_q + tos_q;
                end
                K_SUB: begin
                  do_pop  = 1'b1;
                  pop_val = nos_q - tos_q;
                end
                K_MUL: begin
                  state_d = S_MULW;
                end
                default: begin
                  if (tos_q == '0) begin
                    status_d = ST_DIVZ;
                  end else begin
                    div_start = 1'b1;
                    state_d   = S_DIVW;
                  end
                end
              endcase
            end
          end
        endcase
      end
      S_MULW: begin
        do_pop  = 1'b1;
        pop_val = mul_q;
      end
      S_DIVW: begin
        if (div_done) begin
          do_pop  = 1'b1;
          pop_val = div_quo;
        end
      end
      S_FILL: begin
        nos_d   = rd_q;
        state_d = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d  = 1'b1;
          out_top_d    = (cnt_q != '0) ? tos_q : '0;
          out_depth_d  = DEPTH_W'(cnt_q);
          out_status_d = status_q;
          out_last_d   = item_q.last;
          if (item_q.last) begin
            cnt_d = '0;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // collapse two operands into one; refill the second slot from memory if it holds more
    if (do_pop) begin
      tos_d = pop_val;
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q >= CntW'(3)) begin
        rd_en   = 1'b1;
        state_d = S_FILL;
      end else begin
        state_d = S_FIN;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q       <= item_d;
    tos_q        <= tos_d;
    nos_q        <= nos_d;
    status_q     <= status_d;
    mul_q        <= DATA_W'(nos_q * tos_q);
    out_top_q    <= out_top_d;
    out_depth_q  <= out_depth_d;
    out_status_q <= out_status_d;
    out_last_q   <= out_last_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[waddr_full[AddrW-1:0]] <= nos_q;
    end
    if (rd_en) begin
      rd_q <= mem_q[raddr_full[AddrW-1:0]];
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.top_value = $signed(out_top_q);
  assign out_o.depth     = out_depth_q;
  assign out_o.status    = out_status_q;
  assign out_o.last      = out_last_q;

endmodule

`default_nettype wire

// ===== src/postfix_stack_evaluator_unit.sv =====
// Order: a request passes execute, then finish, which loads the output register;
//   multiply adds a product state, divide waits on the divider, and a pop that
//   needs a refill adds a fill state. Throughput: one request at a time in the
//   execute side; the 32-step divider sets the worst case.
// Reset: rst_ni clears the stack count, queue and handshakes; stack memory holds garbage.
`default_nettype none

// Postfix evaluator top level.
//
// The front side decodes each request's token kind and drops it into a two-entry
// queue, so new requests are taken while the back side is busy or while a result
// waits in the output register.
//
// The back side keeps the two topmost stack entries in registers and the rest in
// a single-port memory; a pop refills the second register from memory through a
// fill state if memory holds entries. Multiply goes through one registered product,
// divide through a bit-serial divider on magnitudes that fixes the sign after.
//
// Underflow, overflow and division by zero leave the stack untouched and only
// report a status. A request flagged last empties the stack once its result is out.
module postfix_stack_evaluator_unit import pse_pkg::*; #(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  pse_in_if.sink     in_i,
  pse_out_if.source  out_o
);

  // front to queue
  logic  wr_valid;
  item_t wr_item;
  logic  q_full;

  // queue to back
  logic  q_valid;
  item_t q_item;
  logic  q_pop;

  // decode and admit requests
  pse_front u_front (
    .in_i       (in_i),
    .full_i     (q_full),
    .wr_valid_o (wr_valid),
    .wr_item_o  (wr_item)
  );

  // hold decoded requests between the two sides
  pse_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (wr_valid),
    .wr_item_i  (wr_item),
    .full_o     (q_full),
    .rd_valid_o (q_valid),
    .rd_item_o  (q_item),
    .rd_pop_i   (q_pop)
  );

  // execute against the stack and register the result
  pse_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_item_i  (q_item),
    .q_pop_o   (q_pop),
    .out_o     (out_o)
  );

endmodule

`default_nettype wire

// ===== src/pse_checker.sv =====
`default_nettype none
`include "postfix_stack_evaluator_unit_assert.svh"

module pse_checker import pse_pkg::*; #(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      out_valid_i,
  input wire logic                      out_ready_i,
  input wire logic signed [DATA_W-1:0]  top_value_i,
  input wire logic [DEPTH_W-1:0]        depth_i,
  input wire logic [STATUS_W-1:0]       status_i,
  input wire logic                      last_i
);

  `PSE_ASSERT_NXT(a_out_valid_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)
  `PSE_ASSERT_NXT(a_out_payload_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(top_value_i) && $stable(depth_i) && $stable(status_i) && $stable(last_i))
  `PSE_ASSERT_IMP(a_over_when_full, clk_i, rst_ni, out_valid_i && status_i == ST_OVER, depth_i == DEPTH_W'(STACK_DEPTH))
  `PSE_ASSERT_IMP(a_under_when_short, clk_i, rst_ni, out_valid_i && status_i == ST_UNDER, depth_i < DEPTH_W'(2))
  `PSE_ASSERT_IMP(a_divz_zero_top, clk_i, rst_ni, out_valid_i && status_i == ST_DIVZ, top_value_i == '0)

endmodule

bind postfix_stack_evaluator_unit pse_checker #(
  .STACK_DEPTH (STACK_DEPTH)
) u_pse_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .top_value_i (out_o.top_value),
  .depth_i     (out_o.depth),
  .status_i    (out_o.status),
  .last_i      (out_o.last)
);

`default_nettype wire

// ===== tb/tb_postfix_stack_evaluator_unit.sv =====
module tb_postfix_stack_evaluator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import pse_pkg::*;

  // Token kinds above divide; the block must ignore them.
  localparam logic [FUNC_W-1:0] FUNC_SKIP_LO  = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_SKIP_MID = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_SKIP_HI  = 3'd7;

  localparam logic [NUM_W-1:0] NUM_MAX = {NUM_W{1'b1}};

  // One evaluation report, as the output channel carries it.
  typedef struct {
    logic signed [DATA_W-1:0] top_value;
    logic [DEPTH_W-1:0]       depth;
    logic [STATUS_W-1:0]      status;
    logic                     last;
  } stack_report_t;

  // Shadow of the evaluator: a private copy of the stack, the reports that
  // the accepted tokens are owed, and the comparison against what comes out.
  class evaluator_ledger;
    logic [DATA_W-1:0] stack_mem [STACK_DEPTH_DEF];
    int unsigned       stack_fill;
    stack_report_t     owed_reports[$];
    int unsigned       errors;
    int unsigned       reports_seen;
    int unsigned       status_seen[4];
    int unsigned       deepest;

    function new();
      stack_fill   = 0;
      errors       = 0;
      reports_seen = 0;
      deepest      = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function int unsigned pending();
      return owed_reports.size();
    endfunction

    // Signed division that truncates toward zero, worked on magnitudes.
    function logic [DATA_W-1:0] quotient_toward_zero(logic [DATA_W-1:0] lhs,
                                                     logic [DATA_W-1:0] rhs);
      logic [DATA_W-1:0] mag_l;
      logic [DATA_W-1:0] mag_r;
      logic [DATA_W-1:0] quo;
      mag_l = lhs[DATA_W-1] ? -lhs : lhs;
      mag_r = rhs[DATA_W-1] ? -rhs : rhs;
      quo   = mag_l / mag_r;
      return (lhs[DATA_W-1] ^ rhs[DATA_W-1]) ? -quo : quo;
    endfunction

    // Apply one accepted token to the shadow stack and queue its report.
    function void note_request(logic [FUNC_W-1:0] func, logic [NUM_W-1:0] number,
                               logic last_tok);
      stack_report_t     rep;
      logic [DATA_W-1:0] lhs;
      logic [DATA_W-1:0] rhs;
      logic [DATA_W-1:0] res;
      logic [STATUS_W-1:0] st;
      st  = ST_OK;
      res = '0;
      if (func == FUNC_PUSH) begin
        if (stack_fill >= STACK_DEPTH_DEF) begin
          st = ST_OVER;
        end else begin
          stack_mem[stack_fill] = {1'b0, number};
          stack_fill++;
        end
      end else if (func <= FUNC_DIV) begin
        if (stack_fill < 2) begin
          st = ST_UNDER;
        end else begin
          rhs = stack_mem[stack_fill-1];
          lhs = stack_mem[stack_fill-2];
          case (func)
            FUNC_ADD: res = lhs + rhs;
            FUNC_SUB: res = lhs - rhs;
            FUNC_MUL: res = lhs * rhs;
            default: begin
              if (rhs == '0) st = ST_DIVZ;
              else res = quotient_toward_zero(lhs, rhs);
            end
          endcase
          if (st == ST_OK) begin
            stack_fill--;
            stack_mem[stack_fill-1] = res;
          end
        end
      end
      rep.top_value = (stack_fill > 0) ? stack_mem[stack_fill-1] : '0;
      rep.depth     = stack_fill[DEPTH_W-1:0];
      rep.status    = st;
      rep.last      = last_tok;
      owed_reports.insert(owed_reports.size(), rep);
      if (stack_fill > deepest) deepest = stack_fill;
      if (last_tok) stack_fill = 0;
    endfunction

    // Compare one delivered report with the oldest one owed.
    function void check_report(logic signed [DATA_W-1:0] top_value,
                               logic [DEPTH_W-1:0] depth,
                               logic [STATUS_W-1:0] status, logic last);
      stack_report_t want;
      if (owed_reports.size() == 0) begin
        $error("report with none owed: top_value %0d depth %0d status %0d last %0b",
               top_value, depth, status, last);
        errors++;
        return;
      end
      want = owed_reports.pop_front();
      reports_seen++;
      status_seen[want.status]++;
      if (top_value !== want.top_value) begin
        $error("top_value: expected %0d, got %0d", want.top_value, top_value);
        errors++;
      end
      if (depth !== want.depth) begin
        $error("depth: expected %0d, got %0d", want.depth, depth);
        errors++;
      end
      if (status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, status);
        errors++;
      end
      if (last !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  pse_in_if  in_if ();
  pse_out_if out_if ();

  postfix_stack_evaluator_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  evaluator_ledger ledger;

  int          send_idle_pct;
  int          recv_idle_pct;
  int          hold_rx;       // cycles the receiver still has to hold off
  int unsigned useful_sent;   // accepted tokens that are not ignored kinds

  always #5 clk_i = ~clk_i;

  // Receiver: own the ready line. A long hold-off, once requested, is counted
  // down here cycle by cycle; otherwise drop ready at the current idle rate.
  always @(negedge clk_i) begin
    if (hold_rx > 0) begin
      out_if.ready <= 1'b0;
      hold_rx      <= hold_rx - 1;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Observe both channels at the rising edge. Note the accepted token before
  // checking, although the block can never answer within the same cycle.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready)
        ledger.note_request(in_if.func, in_if.number, in_if.last_token);
      if (out_if.valid && out_if.ready)
        ledger.check_report(out_if.top_value, out_if.depth, out_if.status,
                            out_if.last);
    end
  end

  // Offer one token and hold it until the block takes it. Entered and left on
  // a falling edge; valid stays high on the way out so back-to-back tokens
  // leave no gap unless the idle roll asks for one.
  task automatic send_token(logic [FUNC_W-1:0] f, logic [NUM_W-1:0] n, logic lt);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk_i);
    end
    in_if.func       = f;
    in_if.number     = n;
    in_if.last_token = lt;
    in_if.valid      = 1'b1;
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
    if (f <= FUNC_DIV) useful_sent++;
  endtask

  function automatic logic [FUNC_W-1:0] pick_operator();
    case ($urandom_range(3))
      0:       return FUNC_ADD;
      1:       return FUNC_SUB;
      2:       return FUNC_MUL;
      default: return FUNC_DIV;
    endcase
  endfunction

  // Bias operands toward zero, one and the top of the range so that
  // division by zero, wrap-around and exact quotients come up often.
  function automatic logic [NUM_W-1:0] pick_number();
    case ($urandom_range(9))
      0:       return '0;
      1:       return NUM_MAX;
      2, 3:    return NUM_W'($urandom_range(20));
      4:       return NUM_W'($urandom_range(2));
      default: return NUM_W'($urandom());
    endcase
  endfunction

  // Send a well-formed postfix expression with the given number of operands;
  // operators are interleaved at random and the final token is marked last.
  // Beyond the stack depth the expression may overflow, which is intended.
  task automatic send_expression(int unsigned operands);
    int unsigned left;
    int unsigned held;
    logic [FUNC_W-1:0] f;
    logic [NUM_W-1:0]  n;
    left = operands;
    held = 0;
    while (left > 0 || held > 1) begin
      if (held >= 2 && (left == 0 || $urandom_range(2) == 0)) begin
        f = pick_operator();
        n = NUM_W'($urandom());
        held--;
      end else begin
        f = FUNC_PUSH;
        n = pick_number();
        left--;
        held++;
      end
      send_token(f, n, (left == 0 && held <= 1));
    end
  endtask

  // Unstructured tokens: any kind, any number, an occasional last marker.
  task automatic send_noise(int unsigned count);
    repeat (count)
      send_token(FUNC_W'($urandom_range(7)), NUM_W'($urandom()),
                 ($urandom_range(7) == 0));
  endtask

  // Mostly short expressions, some deep enough to overflow, some noise.
  task automatic run_random(int unsigned target);
    while (useful_sent < target) begin
      case ($urandom_range(9))
        0:       send_noise($urandom_range(1, 6));
        1:       send_expression($urandom_range(12, 20));
        default: send_expression($urandom_range(1, 6));
      endcase
    end
  endtask

  // Hand-picked tokens for the corner cases of the evaluator.
  task automatic run_directed();
    logic [NUM_W-1:0] fill_val;
    // operator on an empty stack, then with one entry: both underflow
    send_token(FUNC_ADD, NUM_MAX, 1'b0);
    send_token(FUNC_PUSH, NUM_MAX, 1'b0);
    send_token(FUNC_DIV, '0, 1'b0);
    // largest positive plus one wraps to the most negative value
    send_token(FUNC_PUSH, 31'd1, 1'b0);
    send_token(FUNC_ADD, '0, 1'b0);
    // build minus one, then most negative over minus one wraps back
    send_token(FUNC_PUSH, '0, 1'b0);
    send_token(FUNC_PUSH, 31'd1, 1'b0);
    send_token(FUNC_SUB, '0, 1'b0);
    send_token(FUNC_DIV, NUM_MAX, 1'b0);
    // fill the stack to the brim above the most negative value
    for (int i = 2; i <= 16; i++) begin
      case (i)
        12:      fill_val = NUM_MAX;
        13:      fill_val = 31'd7;
        14:      fill_val = 31'd3;
        15:      fill_val = 31'd5;
        16:      fill_val = '0;
        default: fill_val = (i % 2 == 0) ? 31'h2AAA_AAAA : 31'h5555_5555;
      endcase
      send_token(FUNC_PUSH, fill_val, 1'b0);
    end
    // one push too many, then divide by the zero on top
    send_token(FUNC_PUSH, NUM_MAX, 1'b0);
    send_token(FUNC_DIV, '0, 1'b0);
    // unwind: 5+0, 3-5, 7/-2 truncated toward zero, wrapping multiply
    send_token(FUNC_ADD, '0, 1'b0);
    send_token(FUNC_SUB, '0, 1'b0);
    send_token(FUNC_DIV, '0, 1'b0);
    send_token(FUNC_MUL, '0, 1'b0);
    // ignored kinds; the last one also clears a deep stack
    send_token(FUNC_SKIP_LO, NUM_MAX, 1'b0);
    send_token(FUNC_SKIP_MID, '0, 1'b0);
    send_token(FUNC_SKIP_HI, NUM_MAX, 1'b1);
  endtask

  task automatic wait_all_reports();
    while (ledger.pending() != 0) @(negedge clk_i);
  endtask

  initial begin
    ledger           = new();
    clk_i            = 1'b0;
    rst_ni           = 1'b0;
    in_if.valid      = 1'b0;
    in_if.func       = FUNC_PUSH;
    in_if.number     = '0;
    in_if.last_token = 1'b0;
    out_if.ready     = 1'b0;
    hold_rx          = 0;
    useful_sent      = 0;
    send_idle_pct    = 16;
    recv_idle_pct    = 80;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // sender mostly busy, receiver mostly stalling
    run_directed();
    run_random(200);

    // swap: sender mostly idle, receiver mostly ready
    send_idle_pct = 80;
    recv_idle_pct = 16;
    run_random(380);

    // flat out on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(500);

    // Back-pressure: hold the receiver off for a long stretch while tokens
    // keep coming, so the queue fills and the input side stalls.
    in_if.valid = 1'b0;
    @(posedge clk_i);
    hold_rx = 400;
    @(negedge clk_i);
    while (useful_sent < 530) send_expression($urandom_range(2, 8));

    // pause the sender until the block has answered everything
    in_if.valid = 1'b0;
    wait_all_reports();
    run_random(560);

    // drain, then watch a while longer for stray reports
    in_if.valid = 1'b0;
    wait_all_reports();
    repeat (60) @(posedge clk_i);

    $display("Covered %0d reports: %0d ok, %0d underflow, %0d overflow, %0d divide by zero.",
             ledger.reports_seen, ledger.status_seen[ST_OK], ledger.status_seen[ST_UNDER],
             ledger.status_seen[ST_OVER], ledger.status_seen[ST_DIVZ]);
    $display("Deepest stack reached: %0d of %0d entries.", ledger.deepest, STACK_DEPTH_DEF);
    if (ledger.errors == 0 && ledger.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
